// File: hw/rtl/mbd_pkg.sv
// Shared types and constants for the RGBA8 2x2 mip downsampler.
// No dependencies; every other file of the block but mbd_ram imports this package.
`timescale 1ns / 1ps

package mbd_pkg;

    localparam int PIX_W   = 32;          // packed RGBA8 pixel
    localparam int NUM_CH  = 4;
    localparam int CH_W    = 8;           // one channel of a pixel
    localparam int HS_W    = 9;           // one channel of a horizontal pair sum
    localparam int HSUM_W  = NUM_CH * HS_W;
    localparam int CFG_W   = 13;          // stored width of a dimension register
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from paddr bit 2.
    typedef enum logic {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } t_reg_idx;

    // What the position tracker decides for the item being accepted.
    typedef struct packed {
        logic emit;        // the item completes a 2x2 block
        logic ram_rd;      // odd row: fetch the stored pair sum
        logic ram_wr;      // even row: park the pair sum
        logic capture;     // even column: hold the pixel for its partner
        logic dbl_self;    // one-pixel-wide source: the pixel pairs with itself
        logic other_self;  // one-row-high source: the pair sum pairs with itself
        logic last;        // final output pixel of the level
    } t_step;

endpackage

// File: hw/rtl/mbd_pix_if.sv
// Input channel of the downsampler: one source pixel per item.
// Depends on mbd_pkg for the pixel width.
`timescale 1ns / 1ps

interface mbd_pix_if;
    import mbd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_rgba;

    modport source (output valid, output pixel_rgba, input ready);
    modport sink   (input valid, input pixel_rgba, output ready);
endinterface

// File: hw/rtl/mbd_out_if.sv
// Output channel of the downsampler: one averaged pixel per item.
// Depends on mbd_pkg for the pixel width.
`timescale 1ns / 1ps

interface mbd_out_if;
    import mbd_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_rgba;
    logic             level_last;

    modport source (output valid, output out_rgba, output level_last, input ready);
    modport sink   (input valid, input out_rgba, input level_last, output ready);
endinterface

// File: hw/rtl/mip_box_downsample_rgba8.sv
// 2x2 box-filter mip downsampler for packed RGBA8 pixels, top level.
// A block-completing item is registered in the block stage and then in the output register.
// Throughput: one source pixel per cycle while the output is not stalled, using the line store's separate ports.
// Reset (synchronous, active low) clears the pipeline and sets both dimensions to one;
// the line store is not cleared, since an odd row only reads what its even row wrote.
// Depends on mbd_pkg, mbd_pix_if, mbd_out_if, mbd_ram, mbd_lane and mbd_ctrl.
`timescale 1ns / 1ps

module mip_box_downsample_rgba8 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbd_pkg::PADDR_W-1:0] paddr,
    input  logic [mbd_pkg::PDATA_W-1:0] pwdata,
    output logic [mbd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    mbd_pix_if.sink                     i_pix,
    mbd_out_if.source                   o_out
);
    import mbd_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    t_step             step;
    logic [AW-1:0]     addr;
    logic              in_accept, s1_adv;
    logic              ram_we, ram_re;
    logic [HSUM_W-1:0] hsum, ram_rdata, other;
    logic [PIX_W-1:0]  avg_rgba;

    logic              r_s1_valid, r_s1_self, r_s1_last;
    logic [HSUM_W-1:0] r_s1_hsum;
    logic [PIX_W-1:0]  r_pair;
    logic              r_out_valid, r_out_last;
    logic [PIX_W-1:0]  r_out_rgba;

    mbd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_accept (in_accept),
        .o_step   (step),
        .o_addr   (addr)
    );

    // Block stage moves on whenever the output register is free or being emptied.
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_accept   = i_pix.valid && i_pix.ready;

    assign ram_we = in_accept && step.ram_wr;
    assign ram_re = in_accept && step.ram_rd;

    mbd_ram #(
        .WIDTH (HSUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (hsum),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    assign other = r_s1_self ? r_s1_hsum : ram_rdata;

    // Channel lanes: pair sums for the incoming pixel, block means for the held item.
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        mbd_lane u_lane (
            .i_px    (i_pix.pixel_rgba[c*CH_W +: CH_W]),
            .i_pair  (r_pair[c*CH_W +: CH_W]),
            .i_dbl   (step.dbl_self),
            .i_sum_a (r_s1_hsum[c*HS_W +: HS_W]),
            .i_sum_b (other[c*HS_W +: HS_W]),
            .o_hsum  (hsum[c*HS_W +: HS_W]),
            .o_avg   (avg_rgba[c*CH_W +: CH_W])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= step.emit;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_hsum <= hsum;
            r_s1_self <= step.other_self;
            r_s1_last <= step.last;
        end
        if (in_accept && step.capture) begin
            r_pair <= i_pix.pixel_rgba;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Merge: the lane means are packed back into one pixel.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_rgba <= avg_rgba;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_rgba   = r_out_rgba;
    assign o_out.level_last = r_out_last;

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv && !in_accept |=> r_s1_valid)
        else $error("held block item was lost while stalled");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> (!r_s1_valid || s1_adv))
        else $error("item accepted over an unmoved block item");

    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store read and written by the same item");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_pix.ready)
        else $error("input stalled while the output register is empty");

endmodule

// File: hw/rtl/mbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read, so a stalled consumer keeps it.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mbd_lane.sv
// One color channel of the downsampler: horizontal pair sum and rounded block mean.
// Depends on mbd_pkg for channel widths.
`timescale 1ns / 1ps

module mbd_lane (
    input  logic [mbd_pkg::CH_W-1:0] i_px,
    input  logic [mbd_pkg::CH_W-1:0] i_pair,
    input  logic                     i_dbl,
    input  logic [mbd_pkg::HS_W-1:0] i_sum_a,
    input  logic [mbd_pkg::HS_W-1:0] i_sum_b,
    output logic [mbd_pkg::HS_W-1:0] o_hsum,
    output logic [mbd_pkg::CH_W-1:0] o_avg
);
    import mbd_pkg::*;

    logic [CH_W-1:0] partner;
    logic [HS_W:0]   block_sum;

    assign partner = i_dbl ? i_px : i_pair;
    assign o_hsum  = HS_W'(partner) + HS_W'(i_px);

    // Four pixels of at most 255 each plus the rounding term stay below 1024.
    assign block_sum = (HS_W+1)'(i_sum_a) + (HS_W+1)'(i_sum_b) + (HS_W+1)'(2);
    assign o_avg     = block_sum[HS_W:2];

endmodule

// File: hw/rtl/mbd_ctrl.sv
// Configuration registers and raster position tracking for the downsampler.
// Depends on mbd_pkg; decides per item whether it is held, parked, fetched or emitted.
`timescale 1ns / 1ps

module mbd_ctrl #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbd_pkg::PADDR_W-1:0]         paddr,
    input  logic [mbd_pkg::PDATA_W-1:0]         pwdata,
    output logic [mbd_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                i_accept,
    output mbd_pkg::t_step                      o_step,
    output logic [((MAX_WIDTH/2) > 1 ? $clog2(MAX_WIDTH/2) : 1)-1:0] o_addr
);
    import mbd_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int XW_RAW = $clog2(MAX_WIDTH);
    localparam int XW     = (XW_RAW < 2) ? 2 : XW_RAW;
    localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    // Zero counts as one, anything above the line size is clamped to it.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] e;
        e = CMP_W'(v);
        if (v == '0) begin
            e = CMP_W'(1);
        end else if (e > CMP_W'(MAX_WIDTH)) begin
            e = CMP_W'(MAX_WIDTH);
        end
        return e[DIM_W-1:0];
    endfunction

    logic [CFG_W-1:0] r_src_width, r_src_height;
    logic             r_w_one, r_w_odd, r_h_one, r_h_odd;
    logic [XW-1:0]    r_w_m1, r_h_m1;
    logic [XW-2:0]    r_ow_m1, r_oh_m1;
    logic [XW-1:0]    r_x, r_y, n_x, n_y;

    logic             cfg_wr;
    t_reg_idx         reg_idx;
    logic [DIM_W-1:0] wr_dim, wr_dim_m1, wr_half, wr_out_m1;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        case (reg_idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(r_src_width);
            REG_SRC_HEIGHT: prdata = PDATA_W'(r_src_height);
            default:        prdata = '0;
        endcase
    end

    // Derived limits of the dimension being written.
    always_comb begin
        wr_dim    = eff_dim(pwdata[CFG_W-1:0]);
        wr_dim_m1 = wr_dim - DIM_W'(1);
        wr_half   = wr_dim >> 1;
        if (wr_half == '0) begin
            wr_half = DIM_W'(1);
        end
        wr_out_m1 = wr_half - DIM_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= CFG_W'(1);
            r_src_height <= CFG_W'(1);
            r_w_one      <= 1'b1;
            r_w_odd      <= 1'b1;
            r_w_m1       <= '0;
            r_ow_m1      <= '0;
            r_h_one      <= 1'b1;
            r_h_odd      <= 1'b1;
            r_h_m1       <= '0;
            r_oh_m1      <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SRC_WIDTH: begin
                    r_src_width <= pwdata[CFG_W-1:0];
                    r_w_one     <= (wr_dim == DIM_W'(1));
                    r_w_odd     <= wr_dim[0];
                    r_w_m1      <= wr_dim_m1[XW-1:0];
                    r_ow_m1     <= wr_out_m1[XW-2:0];
                end
                REG_SRC_HEIGHT: begin
                    r_src_height <= pwdata[CFG_W-1:0];
                    r_h_one      <= (wr_dim == DIM_W'(1));
                    r_h_odd      <= wr_dim[0];
                    r_h_m1       <= wr_dim_m1[XW-1:0];
                    r_oh_m1      <= wr_out_m1[XW-2:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Raster position of the next source pixel.
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (i_accept) begin
            if (r_x == r_w_m1) begin
                n_x = '0;
                n_y = (r_y == r_h_m1) ? '0 : r_y + XW'(1);
            end else begin
                n_x = r_x + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    logic          x_in, y_in, have_h;
    logic [XW-2:0] ox, oy;

    // The last column or row of an odd dimension above one is dropped.
    assign x_in   = !(r_w_odd && (r_x == r_w_m1));
    assign y_in   = !(r_h_odd && (r_y == r_h_m1));
    assign have_h = r_w_one || (x_in && r_x[0]);
    assign ox     = r_x[XW-1:1];
    assign oy     = r_h_one ? '0 : r_y[XW-1:1];

    always_comb begin
        o_step.capture    = !r_w_one && x_in && !r_x[0];
        o_step.dbl_self   = r_w_one;
        o_step.other_self = r_h_one;
        o_step.ram_wr     = have_h && !r_h_one && y_in && !r_y[0];
        o_step.ram_rd     = have_h && !r_h_one && y_in && r_y[0];
        o_step.emit       = have_h && (r_h_one || (y_in && r_y[0]));
        o_step.last       = (ox == r_ow_m1) && (oy == r_oh_m1);
    end

    assign o_addr = r_x[AW:1];

endmodule
